/* rtl/core/crc8r_pkg.sv */
package crc8r_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic CSR_IDX_HEAD_BYTE = 1'b0;
   localparam logic [7:0] HEAD_BYTE_RESET = 8'hEF;

   localparam logic [7:0] SECOND_BYTE = 8'h01;
   localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

   localparam logic [2:0] STATUS_IGNORED  = 3'd0;
   localparam logic [2:0] STATUS_ACCEPTED = 3'd1;
   localparam logic [2:0] STATUS_GOOD     = 3'd2;
   localparam logic [2:0] STATUS_CRC_BAD  = 3'd3;
   localparam logic [2:0] STATUS_ABORTED  = 3'd4;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] byte_out;
      logic [8:0] byte_position;
      logic       frame_last;
   } result_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] x;
      x = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (x[0]) begin
            x = (x >> 1) ^ CRC_POLY_REFL;
         end else begin
            x = x >> 1;
         end
      end
      return x;
   endfunction

endpackage

/* rtl/core/crc8r_frame.sv */
module crc8r_frame #(
   parameter int unsigned HEADER_LEN = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             head_byte,
   output crc8r_pkg::result_type  result
);

   localparam logic [8:0] HDR_LEN  = 9'(HEADER_LEN);
   localparam logic [8:0] HDR_LAST = 9'(HEADER_LEN - 1);

   logic [8:0] pos_ff;
   logic [8:0] pos_in;
   logic [7:0] len_ff;
   logic [7:0] len_in;
   logic [7:0] crc_ff;
   logic [7:0] crc_in;
   logic [8:0] final_pos;

   assign final_pos = HDR_LEN + {1'b0, len_ff} - 9'd1;

   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      result.status = crc8r_pkg::STATUS_IGNORED;
      result.byte_out = rx_byte;
      result.byte_position = pos_ff;
      result.frame_last = 1'b0;
      priority if (pos_ff == 9'd0) begin
         if (rx_byte == head_byte) begin
            result.status = crc8r_pkg::STATUS_ACCEPTED;
            crc_in = crc8r_pkg::crc8_step(8'd0, rx_byte);
            pos_in = 9'd1;
         end
      end else if (pos_ff == 9'd1) begin
         if (rx_byte == crc8r_pkg::SECOND_BYTE) begin
            result.status = crc8r_pkg::STATUS_ACCEPTED;
            crc_in = crc8r_pkg::crc8_step(crc_ff, rx_byte);
            pos_in = 9'd2;
         end else begin
            result.status = crc8r_pkg::STATUS_ABORTED;
            result.frame_last = 1'b1;
            pos_in = 9'd0;
            len_in = 8'd0;
            crc_in = 8'd0;
         end
      end else if (pos_ff < HDR_LEN) begin
         if (pos_ff == HDR_LAST && rx_byte == 8'd0) begin
            result.status = crc8r_pkg::STATUS_ABORTED;
            result.frame_last = 1'b1;
            pos_in = 9'd0;
            len_in = 8'd0;
            crc_in = 8'd0;
         end else begin
            result.status = crc8r_pkg::STATUS_ACCEPTED;
            if (pos_ff == HDR_LAST) begin
               len_in = rx_byte;
            end
            crc_in = crc8r_pkg::crc8_step(crc_ff, rx_byte);
            pos_in = pos_ff + 9'd1;
         end
      end else if (pos_ff < final_pos) begin
         result.status = crc8r_pkg::STATUS_ACCEPTED;
         crc_in = crc8r_pkg::crc8_step(crc_ff, rx_byte);
         pos_in = pos_ff + 9'd1;
      end else begin
         result.status = (rx_byte == crc_ff) ? crc8r_pkg::STATUS_GOOD
                                             : crc8r_pkg::STATUS_CRC_BAD;
         result.frame_last = 1'b1;
         pos_in = 9'd0;
         len_in = 8'd0;
         crc_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 9'd0;
         len_ff <= 8'd0;
         crc_ff <= 8'd0;
      end else if (advance) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         crc_ff <= crc_in;
      end
   end

endmodule

/* rtl/core/crc8_checked_frame_receiver.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_rx_byte
// rsp       out        rsp_valid/rsp_ready  rsp_status, rsp_byte_out, rsp_byte_position,
//                                           rsp_frame_last
// csr       in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A beat is accepted into the input register; as it moves on, the frame decoder and
// CRC-8 step load its result into the result register, which drives the rsp channel.
// A new beat can be accepted every cycle while the result is not stalled; the frame state
// advances as a beat moves into the result register, through one combinational CRC step.
// Reset is synchronous and returns the decoder to idle with the head byte at 0xEF.
// A stalled result holds the input register, which then stalls the request side.
module crc8_checked_frame_receiver #(
   parameter int unsigned HEADER_LEN = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [7:0]                         rsp_byte_out,
   output logic [8:0]                         rsp_byte_position,
   output logic                               rsp_frame_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [crc8r_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crc8r_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [crc8r_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  rsp_valid_ff;
   crc8r_pkg::result_type rsp_ff;
   crc8r_pkg::result_type result;
   logic [7:0]            head_byte_ff;
   logic                  move;
   logic                  csr_write;
   logic                  csr_hit;

   assign move = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;

   assign pready = 1'b1;
   assign csr_hit = (paddr[crc8r_pkg::CSR_ADDR_W-1] == crc8r_pkg::CSR_IDX_HEAD_BYTE);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata = csr_hit ? {{(crc8r_pkg::CSR_DATA_W-8){1'b0}}, head_byte_ff}
                           : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff <= crc8r_pkg::HEAD_BYTE_RESET;
      end else if (csr_write) begin
         head_byte_ff <= pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   crc8r_frame #(
      .HEADER_LEN (HEADER_LEN)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .advance   (move),
      .rx_byte   (in_byte_ff),
      .head_byte (head_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_byte_out = rsp_ff.byte_out;
   assign rsp_byte_position = rsp_ff.byte_position;
   assign rsp_frame_last = rsp_ff.frame_last;

endmodule

/* rtl/core/crc8r_checker.sv */
module crc8r_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_byte_out,
   input logic [8:0] rsp_byte_position,
   input logic       rsp_frame_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_byte_out) && $stable(rsp_byte_position) && $stable(rsp_frame_last))
      else $error("Stalled result beat changed.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= crc8r_pkg::STATUS_ABORTED)
      else $error("Result status out of range.");

   a_last_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_last == (rsp_status == crc8r_pkg::STATUS_GOOD
         || rsp_status == crc8r_pkg::STATUS_CRC_BAD
         || rsp_status == crc8r_pkg::STATUS_ABORTED))
      else $error("Frame end flag disagrees with status.");

   a_ignored_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == crc8r_pkg::STATUS_IGNORED |-> rsp_byte_position == 9'd0)
      else $error("Ignored beat carries a frame position.");

endmodule

bind crc8_checked_frame_receiver crc8r_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_byte_out      (rsp_byte_out),
   .rsp_byte_position (rsp_byte_position),
   .rsp_frame_last    (rsp_frame_last)
);

/* bench/crc8r_bench_pkg.sv */
`timescale 1ns / 1ps

package crc8r_bench_pkg;

   // Dallas/Maxim CRC-8, reflected, one data bit at a time from the LSB.
   function automatic logic [7:0] maxim_crc_update(input logic [7:0] crc,
                                                   input logic [7:0] data);
      logic [7:0] acc;
      logic       mix;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         mix = acc[0] ^ data[i];
         acc = {1'b0, acc[7:1]};
         if (mix) begin
            acc = acc ^ crc8r_pkg::CRC_POLY_REFL;
         end
      end
      return acc;
   endfunction

endpackage

/* bench/crc8_checked_frame_receiver_checker.sv */
`timescale 1ns / 1ps

module crc8_checked_frame_receiver_checker #(
   parameter int unsigned HEADER_LEN = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [2:0]                       rsp_status,
   input  logic [7:0]                       rsp_byte_out,
   input  logic [8:0]                       rsp_byte_position,
   input  logic                             rsp_frame_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crc8r_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [crc8r_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                             pready,
   output int                               failures,
   output int                               outstanding,
   output int                               results_seen,
   output int                               frames_good,
   output int                               frames_crc_bad,
   output int                               frames_aborted
);

   localparam logic [crc8r_pkg::CSR_ADDR_W-1:0] HEAD_BYTE_ADDR =
      {crc8r_pkg::CSR_IDX_HEAD_BYTE, 2'b00};

   logic [8:0] frame_pos;
   logic [7:0] frame_len;
   logic [7:0] crc_acc;
   logic [7:0] head_value;
   crc8r_pkg::result_type predicted_beats[$];

   initial begin
      failures = 0;
      outstanding = 0;
      results_seen = 0;
      frames_good = 0;
      frames_crc_bad = 0;
      frames_aborted = 0;
   end

   function automatic void frame_idle();
      frame_pos = '0;
      frame_len = '0;
      crc_acc = '0;
   endfunction

   // Advances the frame state by one received byte and gives the result it causes.
   function automatic crc8r_pkg::result_type decode_rx_byte(input logic [7:0] rx);
      crc8r_pkg::result_type r;
      int unsigned crc_pos;
      r.status = crc8r_pkg::STATUS_IGNORED;
      r.byte_out = rx;
      r.byte_position = frame_pos;
      r.frame_last = 1'b0;
      crc_pos = HEADER_LEN + int'(frame_len) - 1;
      if (frame_pos == 0) begin
         if (rx == head_value) begin
            r.status = crc8r_pkg::STATUS_ACCEPTED;
            crc_acc = crc8r_bench_pkg::maxim_crc_update(8'h00, rx);
            frame_pos = 9'd1;
         end
      end else if (frame_pos == 1 && rx != crc8r_pkg::SECOND_BYTE) begin
         r.status = crc8r_pkg::STATUS_ABORTED;
         r.frame_last = 1'b1;
         frame_idle();
      end else if (frame_pos == HEADER_LEN - 1 && rx == 8'h00) begin
         r.status = crc8r_pkg::STATUS_ABORTED;
         r.frame_last = 1'b1;
         frame_idle();
      end else if (frame_pos >= HEADER_LEN && frame_pos >= crc_pos) begin
         r.status = (rx == crc_acc) ? crc8r_pkg::STATUS_GOOD : crc8r_pkg::STATUS_CRC_BAD;
         r.frame_last = 1'b1;
         frame_idle();
      end else begin
         if (frame_pos == HEADER_LEN - 1) begin
            frame_len = rx;
         end
         r.status = crc8r_pkg::STATUS_ACCEPTED;
         crc_acc = crc8r_bench_pkg::maxim_crc_update(crc_acc, rx);
         frame_pos = frame_pos + 9'd1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      failures++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : watch
      crc8r_pkg::result_type want;
      if (reset) begin
         head_value = crc8r_pkg::HEAD_BYTE_RESET;
         frame_idle();
         predicted_beats.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (predicted_beats.size() == 0) begin
               failures++;
               $display("%0t ns: result beat, expected none, actual status %0d byte %0d",
                        $time, rsp_status, rsp_byte_out);
            end else begin
               want = predicted_beats.pop_front();
               if (rsp_status != want.status) begin
                  report_mismatch("status", want.status, rsp_status);
               end
               if (rsp_byte_out != want.byte_out) begin
                  report_mismatch("byte_out", want.byte_out, rsp_byte_out);
               end
               if (rsp_byte_position != want.byte_position) begin
                  report_mismatch("byte_position", want.byte_position, rsp_byte_position);
               end
               if (rsp_frame_last != want.frame_last) begin
                  report_mismatch("frame_last", want.frame_last, rsp_frame_last);
               end
            end
            unique case (rsp_status)
               crc8r_pkg::STATUS_GOOD: frames_good++;
               crc8r_pkg::STATUS_CRC_BAD: frames_crc_bad++;
               crc8r_pkg::STATUS_ABORTED: frames_aborted++;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predicted_beats.push_back(decode_rx_byte(req_rx_byte));
         end
         if (psel && penable && pwrite && pready && paddr == HEAD_BYTE_ADDR) begin
            head_value = pwdata[7:0];
         end
      end
      outstanding = predicted_beats.size();
   end

endmodule

/* bench/crc8_checked_frame_receiver_tb.sv */
`timescale 1ns / 1ps

module crc8_checked_frame_receiver_tb;

   localparam int unsigned HDR_LEN = 9;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam logic [crc8r_pkg::CSR_ADDR_W-1:0] HEAD_BYTE_ADDR =
      {crc8r_pkg::CSR_IDX_HEAD_BYTE, 2'b00};

   typedef enum {FRAME_GOOD, FRAME_CRC_BAD, FRAME_BAD_SECOND, FRAME_ZERO_LEN} frame_kind_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_EVERY_THIRD, READY_RARE_STALL} stall_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_rx_byte = 8'h00;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [2:0]                       rsp_status;
   logic [7:0]                       rsp_byte_out;
   logic [8:0]                       rsp_byte_position;
   logic                             rsp_frame_last;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [crc8r_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [crc8r_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [crc8r_pkg::CSR_DATA_W-1:0] prdata;
   logic                             pready;

   int          chk_failures;
   int          chk_outstanding;
   int          chk_results;
   int          chk_good;
   int          chk_crc_bad;
   int          chk_aborted;
   int unsigned cycle_count;
   int unsigned items_sent = 0;
   int unsigned noise_sent = 0;
   int unsigned burst_left = 0;
   logic        no_gaps = 1'b0;
   logic        hold_off_req = 1'b0;
   logic [7:0]  head_now = crc8r_pkg::HEAD_BYTE_RESET;

   always #10 clock = ~clock;

   crc8_checked_frame_receiver #(
      .HEADER_LEN(HDR_LEN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_byte_out(rsp_byte_out),
      .rsp_byte_position(rsp_byte_position),
      .rsp_frame_last(rsp_frame_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   crc8_checked_frame_receiver_checker #(
      .HEADER_LEN(HDR_LEN)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_byte_out(rsp_byte_out),
      .rsp_byte_position(rsp_byte_position),
      .rsp_frame_last(rsp_frame_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .pready(pready),
      .failures(chk_failures),
      .outstanding(chk_outstanding),
      .results_seen(chk_results),
      .frames_good(chk_good),
      .frames_crc_bad(chk_crc_bad),
      .frames_aborted(chk_aborted)
   );

   // Called and left at a falling edge; the beat is offered until it is taken.
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      if (burst_left == 0 && !no_gaps) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left != 0) begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_frame(input frame_kind_type kind, input int unsigned body_len);
      logic [7:0] crc;
      logic [7:0] b;
      crc = 8'h00;
      send_byte(head_now);
      crc = crc8r_bench_pkg::maxim_crc_update(crc, head_now);
      if (kind == FRAME_BAD_SECOND) begin
         b = 8'($urandom_range(0, 255));
         if (b == crc8r_pkg::SECOND_BYTE) begin
            b = b ^ 8'h80;
         end
         send_byte(b);
         return;
      end
      send_byte(crc8r_pkg::SECOND_BYTE);
      crc = crc8r_bench_pkg::maxim_crc_update(crc, crc8r_pkg::SECOND_BYTE);
      for (int k = 2; k < HDR_LEN - 1; k++) begin
         b = ($urandom_range(0, 3) == 0) ? head_now : 8'($urandom_range(0, 255));
         send_byte(b);
         crc = crc8r_bench_pkg::maxim_crc_update(crc, b);
      end
      if (kind == FRAME_ZERO_LEN) begin
         send_byte(8'h00);
         return;
      end
      b = 8'(body_len);
      send_byte(b);
      crc = crc8r_bench_pkg::maxim_crc_update(crc, b);
      for (int k = 1; k < body_len; k++) begin
         b = 8'($urandom_range(0, 255));
         send_byte(b);
         crc = crc8r_bench_pkg::maxim_crc_update(crc, b);
      end
      if (kind == FRAME_CRC_BAD) begin
         crc = crc ^ 8'($urandom_range(1, 255));
      end
      send_byte(crc);
   endtask

   // Stops offering beats and waits until every result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (chk_outstanding != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_head(input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= HEAD_BYTE_ADDR;
      pwdata <= {{(crc8r_pkg::CSR_DATA_W-8){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      head_now = value;
   endtask

   task automatic run_phase(input int unsigned target);
      int unsigned start_items;
      int unsigned start_noise;
      int unsigned r;
      int unsigned len;
      logic [7:0]  b;
      start_items = items_sent;
      start_noise = noise_sent;
      while ((items_sent - start_items) - (noise_sent - start_noise) < target) begin
         r = $urandom_range(0, 99);
         len = $urandom_range(0, 99);
         len = (len == 0) ? 255 : (len < 3) ? $urandom_range(20, 60) : $urandom_range(1, 10);
         if (r < 8) begin
            b = 8'($urandom_range(0, 255));
            if (b == head_now) begin
               b = b ^ 8'h01;
            end
            send_byte(b);
            noise_sent++;
         end else if (r < 14) begin
            send_frame(FRAME_BAD_SECOND, 0);
         end else if (r < 19) begin
            send_frame(FRAME_ZERO_LEN, 0);
         end else if (r < 29) begin
            send_frame(FRAME_CRC_BAD, len);
         end else begin
            send_frame(FRAME_GOOD, len);
         end
      end
   endtask

   initial begin : rsp_stall
      stall_mode_type mode;
      int unsigned left;
      mode = READY_ALWAYS;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(16, 80);
            end
            left--;
            unique case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               READY_EVERY_THIRD: rsp_ready <= (left % 3 != 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Bytes outside a frame, a repeated head byte as the second byte, a zero length
      // byte and the shortest good frame, all under the head byte out of reset.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(head_now);
      send_byte(head_now);
      send_frame(FRAME_ZERO_LEN, 0);
      send_frame(FRAME_GOOD, 1);
      run_phase(180);

      drain();
      write_head(8'h00);
      run_phase(170);

      drain();
      write_head(8'hFF);
      send_frame(FRAME_GOOD, 255);
      no_gaps = 1'b1;
      hold_off_req = 1'b1;
      send_frame(FRAME_GOOD, 12);
      no_gaps = 1'b0;
      run_phase(150);

      drain();
      write_head(8'($urandom_range(0, 255)));
      run_phase(80);
      drain();
      run_phase(80);

      drain();
      write_head(8'($urandom_range(0, 255)));
      run_phase(150);

      drain();
      write_head(crc8r_pkg::HEAD_BYTE_RESET);
      run_phase(130);

      drain();
      repeat (10) @(negedge clock);

      $display("Sent %0d bytes, %0d of them idle noise, under six head byte settings.",
               items_sent, noise_sent);
      $display("Checked %0d results: %0d good frames, %0d CRC errors, %0d aborted frames.",
               chk_results, chk_good, chk_crc_bad, chk_aborted);
      if (chk_failures == 0 && chk_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
